// ===== design/tvdi_pkg.sv =====
package tvdi_pkg;

  localparam int COMP_W    = 16;
  localparam int SUM_W     = 20;
  localparam int KEY_COMPS = 8;
  localparam int VEC_COMPS = 3;
  localparam int KEY_W     = KEY_COMPS * COMP_W;
  localparam int VEC_W     = VEC_COMPS * COMP_W;
  localparam int SUMV_W    = VEC_COMPS * SUM_W;
  localparam int TOL_W     = 8;
  localparam int IDX_OUT_W = 10;
  localparam int CNT_OUT_W = 11;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [VEC_W-1:0]  vec_t;
  typedef logic [SUMV_W-1:0] sumv_t;
  typedef logic [TOL_W-1:0]  tol_t;

  typedef struct packed {
    logic key_we;
    logic sum_we;
  } tbl_wr_t;

endpackage

// ===== design/tolerant_vertex_dedup_indexer.sv =====
// Channel  Direction  Handshake            Payload
// in_      request    in_valid/in_stall    start flag, position, texture, normal, tangents
// out_     result     out_valid/out_stall  index, new/full flags, sums, unique count
// cfg_     write      cfg_valid/cfg_ready  match tolerance
//
// A request scans the held entries from entry 0 upward through the key memory read port,
// which compares one stored entry per cycle; a match ends the scan early, and a miss or a
// full table scans every held entry. The next request waits until this one is finished.
// Reset is synchronous and active low; it empties the table and sets tolerance to 3.
// The result sits in an output register, so a stalled result does not block the next
// request from being taken and scanned.
module tolerant_vertex_dedup_indexer
  import tvdi_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_start_of_mesh,
  input  logic [47:0]          in_position,
  input  logic [31:0]          in_tex_coord,
  input  logic [47:0]          in_vertex_normal,
  input  logic [47:0]          in_tangent,
  input  logic [47:0]          in_bitangent,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_OUT_W-1:0] out_vertex_index,
  output logic                 out_is_new,
  output logic                 out_table_full,
  output logic [59:0]          out_tangent_sum,
  output logic [59:0]          out_bitangent_sum,
  output logic [CNT_OUT_W-1:0] out_unique_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TOL_W-1:0]     cfg_match_tolerance
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RDSUM, S_ADDT, S_ADDB, S_DONE} state_t;

  state_t               state_r, state_nxt;
  tol_t                 tol_r, tol_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 is_new_r, is_new_nxt;
  logic                 full_r, full_nxt;
  key_t                 key_r, key_nxt;
  vec_t                 tan_r, tan_nxt;
  vec_t                 bit_r, bit_nxt;
  sumv_t                ts_r, ts_nxt;
  sumv_t                bs_r, bs_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0] out_idx_r, out_idx_nxt;
  logic                 out_new_r, out_new_nxt;
  logic                 out_full_r, out_full_nxt;
  sumv_t                out_ts_r, out_ts_nxt;
  sumv_t                out_bs_r, out_bs_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  key_t                   key_rd;
  sumv_t                  tan_rd, bit_rd;
  logic                   hit;
  sumv_t                  acc_sum, acc_out;
  vec_t                   acc_vec;
  logic                   done_fire;
  tbl_wr_t                tbl_wr;
  logic [CNT_W-1:0]       count_after;
  logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  tvdi_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .waddr     (idx_r),
    .wkey      (key_r),
    .wtan      (ts_r),
    .wbit      (bs_r),
    .key_raddr (scan_r[IDX_W-1:0]),
    .sum_raddr (idx_r),
    .key_rd    (key_rd),
    .tan_rd    (tan_rd),
    .bit_rd    (bit_rd)
  );

  tvdi_key_cmp u_cmp (
    .key_a (key_r),
    .key_b (key_rd),
    .tol   (tol_r),
    .match (hit)
  );

  assign acc_vec = (state_r == S_ADDB) ? bit_r : tan_r;
  assign acc_sum = is_new_r ? '0 : ((state_r == S_ADDB) ? bit_rd : tan_rd);

  tvdi_sat_acc u_acc (
    .sum_in  (acc_sum),
    .vec_in  (acc_vec),
    .sum_out (acc_out)
  );

  assign done_fire      = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign tbl_wr.key_we  = done_fire && is_new_r;
  assign tbl_wr.sum_we  = done_fire && !full_r;
  assign count_after    = count_r + CNT_W'(is_new_r);
  assign idx_ext        = {{IDX_OUT_W{1'b0}}, idx_r};
  assign cnt_ext        = {{CNT_OUT_W{1'b0}}, count_after};

  always_comb begin
    state_nxt     = state_r;
    tol_nxt       = tol_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    cmp_idx_nxt   = cmp_idx_r;
    idx_nxt       = idx_r;
    is_new_nxt    = is_new_r;
    full_nxt      = full_r;
    key_nxt       = key_r;
    tan_nxt       = tan_r;
    bit_nxt       = bit_r;
    ts_nxt        = ts_r;
    bs_nxt        = bs_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    out_ts_nxt    = out_ts_r;
    out_bs_nxt    = out_bs_r;
    out_cnt_nxt   = out_cnt_r;

    if (cfg_valid) begin
      tol_nxt = cfg_match_tolerance;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = {in_vertex_normal, in_tex_coord, in_position};
          tan_nxt   = in_tangent;
          bit_nxt   = in_bitangent;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN;
          if (in_start_of_mesh) begin
            count_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && hit) begin
          idx_nxt    = cmp_idx_r;
          is_new_nxt = 1'b0;
          full_nxt   = 1'b0;
          state_nxt  = S_RDSUM;
        end else if (scan_r < count_r) begin
          pend_nxt    = 1'b1;
          cmp_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt    = scan_r + CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else if (count_r < CNT_W'(TABLE_DEPTH)) begin
          idx_nxt    = count_r[IDX_W-1:0];
          is_new_nxt = 1'b1;
          full_nxt   = 1'b0;
          state_nxt  = S_ADDT;
        end else begin
          idx_nxt    = '0;
          is_new_nxt = 1'b0;
          full_nxt   = 1'b1;
          ts_nxt     = '0;
          bs_nxt     = '0;
          state_nxt  = S_DONE;
        end
      end
      S_RDSUM: begin
        state_nxt = S_ADDT;
      end
      S_ADDT: begin
        ts_nxt    = acc_out;
        state_nxt = S_ADDB;
      end
      S_ADDB: begin
        bs_nxt    = acc_out;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_fire) begin
          count_nxt     = count_after;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_ext[IDX_OUT_W-1:0];
          out_new_nxt   = is_new_r;
          out_full_nxt  = full_r;
          out_ts_nxt    = ts_r;
          out_bs_nxt    = bs_r;
          out_cnt_nxt   = cnt_ext[CNT_OUT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= TOL_RESET;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tol_r       <= tol_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    idx_r      <= idx_nxt;
    is_new_r   <= is_new_nxt;
    full_r     <= full_nxt;
    key_r      <= key_nxt;
    tan_r      <= tan_nxt;
    bit_r      <= bit_nxt;
    ts_r       <= ts_nxt;
    bs_r       <= bs_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
    out_ts_r   <= out_ts_nxt;
    out_bs_r   <= out_bs_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_vertex_index  = out_idx_r;
  assign out_is_new        = out_new_r;
  assign out_table_full    = out_full_r;
  assign out_tangent_sum   = out_ts_r;
  assign out_bitangent_sum = out_bs_r;
  assign out_unique_count  = out_cnt_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && pend_r |-> ({1'b0, cmp_idx_r} < {1'b0, count_r}))
    else $error("compared entry beyond filled part of table");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire && is_new_r |=>
      ({1'b0, count_r} == {1'b0, $past(count_r)} + (CNT_W+1)'(1)))
    else $error("append did not advance entry count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_full_r))
    else $error("result flagged both new and full");
`endif

endmodule

// ===== design/tvdi_key_cmp.sv =====
module tvdi_key_cmp
  import tvdi_pkg::*;
(
  input  key_t key_a,
  input  key_t key_b,
  input  tol_t tol,
  output logic match
);

  logic signed [COMP_W:0] diff [KEY_COMPS];
  logic [COMP_W:0]        mag  [KEY_COMPS];
  logic [KEY_COMPS-1:0]   ok;

  for (genvar k = 0; k < KEY_COMPS; k++) begin : g_comp
    assign diff[k] = $signed({key_a[k*COMP_W+COMP_W-1], key_a[k*COMP_W +: COMP_W]})
                   - $signed({key_b[k*COMP_W+COMP_W-1], key_b[k*COMP_W +: COMP_W]});
    assign mag[k]  = diff[k][COMP_W] ? (COMP_W+1)'(-diff[k]) : (COMP_W+1)'(diff[k]);
    assign ok[k]   = mag[k] < (COMP_W+1)'(tol);
  end

  assign match = &ok;

endmodule

// ===== design/tvdi_sat_acc.sv =====
module tvdi_sat_acc
  import tvdi_pkg::*;
(
  input  sumv_t sum_in,
  input  vec_t  vec_in,
  output sumv_t sum_out
);

  logic signed [SUM_W:0] t [VEC_COMPS];

  for (genvar k = 0; k < VEC_COMPS; k++) begin : g_part
    assign t[k] = $signed({sum_in[k*SUM_W+SUM_W-1], sum_in[k*SUM_W +: SUM_W]})
                + $signed({{(SUM_W+1-COMP_W){vec_in[k*COMP_W+COMP_W-1]}},
                           vec_in[k*COMP_W +: COMP_W]});

    always_comb begin
      if (!t[k][SUM_W] && t[k][SUM_W-1]) begin
        sum_out[k*SUM_W +: SUM_W] = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (t[k][SUM_W] && !t[k][SUM_W-1]) begin
        sum_out[k*SUM_W +: SUM_W] = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        sum_out[k*SUM_W +: SUM_W] = t[k][SUM_W-1:0];
      end
    end
  end

endmodule

// ===== design/tvdi_table.sv =====
module tvdi_table
  import tvdi_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] waddr,
  input  key_t             wkey,
  input  sumv_t            wtan,
  input  sumv_t            wbit,
  input  logic [IDX_W-1:0] key_raddr,
  input  logic [IDX_W-1:0] sum_raddr,
  output key_t             key_rd,
  output sumv_t            tan_rd,
  output sumv_t            bit_rd
);

  key_t                  key_mem [DEPTH];
  logic [2*SUMV_W-1:0]   sum_mem [DEPTH];
  logic [2*SUMV_W-1:0]   sum_q;

  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[waddr] <= wkey;
    end
    key_rd <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.sum_we) begin
      sum_mem[waddr] <= {wbit, wtan};
    end
    sum_q <= sum_mem[sum_raddr];
  end

  assign tan_rd = sum_q[SUMV_W-1:0];
  assign bit_rd = sum_q[2*SUMV_W-1:SUMV_W];

endmodule

// ===== dv/tolerant_vertex_dedup_indexer_test.sv =====
module tolerant_vertex_dedup_indexer_test
  import tvdi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH  = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int SUM_MAX    = 524287;
  localparam int SUM_MIN    = -524288;

  typedef logic [15:0] comp_t;

  typedef struct {
    logic        start;
    vec_t        pos;
    logic [31:0] tex;
    vec_t        nrm;
    vec_t        tan;
    vec_t        bitan;
  } vertex_t;

  typedef struct {
    logic [IDX_OUT_W-1:0] idx;
    logic                 is_new;
    logic                 full;
    sumv_t                tsum;
    sumv_t                bsum;
    logic [CNT_OUT_W-1:0] count;
  } index_result_t;

  typedef struct {
    vertex_t       v;
    bit            typed;
    index_result_t r;
  } dir_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_start_of_mesh;
  logic [47:0]          in_position;
  logic [31:0]          in_tex_coord;
  logic [47:0]          in_vertex_normal;
  logic [47:0]          in_tangent;
  logic [47:0]          in_bitangent;
  logic                 out_valid;
  logic                 out_stall;
  logic [IDX_OUT_W-1:0] out_vertex_index;
  logic                 out_is_new;
  logic                 out_table_full;
  logic [59:0]          out_tangent_sum;
  logic [59:0]          out_bitangent_sum;
  logic [CNT_OUT_W-1:0] out_unique_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [TOL_W-1:0]     cfg_match_tolerance;

  tolerant_vertex_dedup_indexer #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_of_mesh   (in_start_of_mesh),
    .in_position        (in_position),
    .in_tex_coord       (in_tex_coord),
    .in_vertex_normal   (in_vertex_normal),
    .in_tangent         (in_tangent),
    .in_bitangent       (in_bitangent),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vertex_index   (out_vertex_index),
    .out_is_new         (out_is_new),
    .out_table_full     (out_table_full),
    .out_tangent_sum    (out_tangent_sum),
    .out_bitangent_sum  (out_bitangent_sum),
    .out_unique_count   (out_unique_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_match_tolerance(cfg_match_tolerance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  vec_t          pos_tbl [TBL_DEPTH];
  logic [31:0]   tex_tbl [TBL_DEPTH];
  vec_t          nrm_tbl [TBL_DEPTH];
  sumv_t         tsum_tbl[TBL_DEPTH];
  sumv_t         bsum_tbl[TBL_DEPTH];
  int            entries;
  tol_t          tolerance;

  index_result_t due_results[$];
  int            mismatches;
  int            n_new;
  int            n_merged;
  int            n_dropped;
  int            n_tols;
  int            peak_count;
  int            burst_left;
  int            idle_cycles;
  int            stall_left;
  stall_mode_t   stall_mode;

  function automatic bit comps_close(logic [47:0] a, logic [47:0] b, int n);
    int d;
    for (int k = 0; k < n; k++) begin
      d = int'($signed(a[k*16 +: 16])) - int'($signed(b[k*16 +: 16]));
      if (d < 0) d = -d;
      if (d >= int'(tolerance)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic sumv_t sat_accumulate(sumv_t acc, vec_t v);
    int    t;
    sumv_t r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      t = int'($signed(acc[k*20 +: 20])) + int'($signed(v[k*16 +: 16]));
      if (t > SUM_MAX) t = SUM_MAX;
      if (t < SUM_MIN) t = SUM_MIN;
      r[k*20 +: 20] = t[19:0];
    end
    return r;
  endfunction

  function automatic index_result_t index_vertex(vertex_t v);
    index_result_t r;
    int            hit;
    r = '{default: '0};
    hit = -1;
    if (v.start) entries = 0;
    for (int i = 0; i < entries; i++) begin
      if (comps_close(v.pos, pos_tbl[i], 3) && comps_close({16'h0, v.tex}, {16'h0, tex_tbl[i]}, 2) &&
          comps_close(v.nrm, nrm_tbl[i], 3)) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      tsum_tbl[hit] = sat_accumulate(tsum_tbl[hit], v.tan);
      bsum_tbl[hit] = sat_accumulate(bsum_tbl[hit], v.bitan);
      r.idx = IDX_OUT_W'(hit);
      r.tsum = tsum_tbl[hit];
      r.bsum = bsum_tbl[hit];
    end else if (entries < TBL_DEPTH) begin
      pos_tbl[entries] = v.pos;
      tex_tbl[entries] = v.tex;
      nrm_tbl[entries] = v.nrm;
      tsum_tbl[entries] = sat_accumulate('0, v.tan);
      bsum_tbl[entries] = sat_accumulate('0, v.bitan);
      r.idx = IDX_OUT_W'(entries);
      r.is_new = 1'b1;
      r.tsum = tsum_tbl[entries];
      r.bsum = bsum_tbl[entries];
      entries++;
    end else begin
      r.full = 1'b1;
    end
    r.count = CNT_OUT_W'(entries);
    return r;
  endfunction

  function automatic dir_row_t row_of(logic start, vec_t pos, logic [31:0] tex, vec_t nrm,
                                      vec_t tan, vec_t bitan, bit typed, int idx,
                                      logic is_new, sumv_t tsum, sumv_t bsum, int count);
    dir_row_t row;
    row.v.start = start;
    row.v.pos = pos;
    row.v.tex = tex;
    row.v.nrm = nrm;
    row.v.tan = tan;
    row.v.bitan = bitan;
    row.typed = typed;
    row.r.idx = IDX_OUT_W'(idx);
    row.r.is_new = is_new;
    row.r.full = 1'b0;
    row.r.tsum = tsum;
    row.r.bsum = bsum;
    row.r.count = CNT_OUT_W'(count);
    return row;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return comp_t'(int'($urandom_range(0, 8)) - 4);
      default: return comp_t'($urandom());
    endcase
  endfunction

  function automatic vec_t rand_vec();
    vec_t r;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: r[k*16 +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        1: r[k*16 +: 16] = comp_t'(int'($urandom_range(0, 64)) - 32);
        default: r[k*16 +: 16] = comp_t'($urandom());
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_vertex(dir_row_t row);
    index_result_t predicted;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(7, 50)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_start_of_mesh <= row.v.start;
    in_position <= row.v.pos;
    in_tex_coord <= row.v.tex;
    in_vertex_normal <= row.v.nrm;
    in_tangent <= row.v.tan;
    in_bitangent <= row.v.bitan;
    do @(posedge clk); while (in_stall);
    predicted = index_vertex(row.v);
    due_results.push_back(row.typed ? row.r : predicted);
    burst_left--;
  endtask

  task automatic set_tolerance(tol_t t);
    in_valid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_match_tolerance <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tolerance = t;
    n_tols++;
  endtask

  // Meshes reuse a small pool of base keys with jitter around the tolerance,
  // so most vertices merge or just miss; one in ten is unrelated noise.
  task automatic run_meshes(int n_items);
    comp_t    pool[12][8];
    comp_t    c[8];
    dir_row_t row;
    int       n_pool;
    int       mesh_len;
    int       pick;
    int       jmax;
    int       sent;
    sent = 0;
    row.typed = 1'b0;
    while (sent < n_items) begin
      n_pool = $urandom_range(1, 12);
      for (int p = 0; p < n_pool; p++)
        for (int k = 0; k < 8; k++) pool[p][k] = rand_comp();
      mesh_len = $urandom_range(1, 40);
      for (int m = 0; m < mesh_len && sent < n_items; m++) begin
        if ($urandom_range(0, 9) == 0) begin
          for (int k = 0; k < 8; k++) c[k] = rand_comp();
        end else begin
          pick = $urandom_range(0, n_pool - 1);
          case ($urandom_range(0, 3))
            0: jmax = 0;
            1: jmax = (tolerance > 0) ? int'(tolerance) - 1 : 0;
            2: jmax = int'(tolerance);
            default: jmax = int'(tolerance) + 2;
          endcase
          for (int k = 0; k < 8; k++)
            c[k] = comp_t'(int'(pool[pick][k]) + int'($urandom_range(0, 2 * jmax)) - jmax);
        end
        row.v.start = (m == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 31) == 0);
        row.v.pos = {c[2], c[1], c[0]};
        row.v.tex = {c[4], c[3]};
        row.v.nrm = {c[7], c[6], c[5]};
        row.v.tan = rand_vec();
        row.v.bitan = rand_vec();
        send_vertex(row);
        sent++;
      end
    end
  endtask

  // Every vertex but one gets its own x position, so with exact matching the table fills to
  // the last entry; after it, one repeats the last entry's key and hits it, the rest hit a full table.
  task automatic fill_table();
    dir_row_t row;
    dir_row_t last_row;
    row.typed = 1'b0;
    for (int i = 0; i < TBL_DEPTH + 4; i++) begin
      row.v.start = (i == 0);
      row.v.pos = {comp_t'($urandom()), comp_t'($urandom()), comp_t'(i)};
      row.v.tex = $urandom();
      row.v.nrm = {comp_t'($urandom()), comp_t'($urandom()), comp_t'($urandom())};
      row.v.tan = rand_vec();
      row.v.bitan = rand_vec();
      if (i == TBL_DEPTH - 1) last_row = row;
      if (i == TBL_DEPTH + 1) begin
        row.v.pos = last_row.v.pos;
        row.v.tex = last_row.v.tex;
        row.v.nrm = last_row.v.nrm;
      end
      send_vertex(row);
    end
  endtask

  always @(posedge clk) begin
    index_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, index %0d", out_vertex_index));
      end else begin
        want = due_results.pop_front();
        if (out_vertex_index !== want.idx)
          report_mismatch($sformatf("vertex_index %0d, expected %0d", out_vertex_index, want.idx));
        if (out_is_new !== want.is_new)
          report_mismatch($sformatf("is_new %b, expected %b", out_is_new, want.is_new));
        if (out_table_full !== want.full)
          report_mismatch($sformatf("table_full %b, expected %b", out_table_full, want.full));
        if (out_tangent_sum !== want.tsum)
          report_mismatch($sformatf("tangent_sum %h, expected %h", out_tangent_sum, want.tsum));
        if (out_bitangent_sum !== want.bsum)
          report_mismatch($sformatf("bitangent_sum %h, expected %h", out_bitangent_sum,
                                    want.bsum));
        if (out_unique_count !== want.count)
          report_mismatch($sformatf("unique_count %0d, expected %0d", out_unique_count,
                                    want.count));
        if (want.is_new) n_new++;
        else if (want.full) n_dropped++;
        else n_merged++;
        if (int'(want.count) > peak_count) peak_count = int'(want.count);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out with %0d results outstanding.", due_results.size());
        $display("tolerant_vertex_dedup_indexer test failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_of_mesh = 1'b0;
    in_position = '0;
    in_tex_coord = '0;
    in_vertex_normal = '0;
    in_tangent = '0;
    in_bitangent = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_match_tolerance = TOL_RESET;
    tolerance = TOL_RESET;
    entries = 0;
    burst_left = 0;
    stall_left = 0;
    idle_cycles = 0;
    mismatches = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Runs at the reset tolerance of 3 LSBs.
    rows.push_back(row_of(1, 48'h0, 32'h0, 48'h0, 48'h0, 48'h0,
                          1, 0, 1, 60'h0, 60'h0, 1));
    rows.push_back(row_of(0, 48'h0, 32'h0, 48'h0, 48'h0, 48'h0,
                          1, 0, 0, 60'h0, 60'h0, 1));
    rows.push_back(row_of(0, 48'h8000_8000_8000, 32'h8000_8000, 48'h8000_8000_8000,
                          48'h7FFF_8000_FFFF, 48'h0001_0000_7FFF,
                          1, 1, 1, 60'h07FFF_F8000_FFFFF, 60'h00001_00000_07FFF, 2));
    rows.push_back(row_of(0, 48'h7FFF_7FFF_7FFF, 32'h7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                          48'h0, 48'h0, 1, 2, 1, 60'h0, 60'h0, 3));
    rows.push_back(row_of(0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                          48'h0, 48'h0, 1, 0, 0, 60'h0, 60'h0, 3));
    rows.push_back(row_of(0, 48'h0002_0002_0002, 32'h0, 48'h0002_0002_0002,
                          48'h0, 48'h0, 1, 0, 0, 60'h0, 60'h0, 3));
    rows.push_back(row_of(0, 48'h0000_0000_0003, 32'h0, 48'h0,
                          48'h0, 48'h0, 1, 3, 1, 60'h0, 60'h0, 4));
    rows.push_back(row_of(0, 48'h0, 32'hFFFD_0000, 48'h0,
                          48'h0, 48'h0, 1, 4, 1, 60'h0, 60'h0, 5));
    // One new vertex and sixteen merges of full-scale tangents drive every sum part into saturation.
    for (int i = 0; i < 17; i++)
      rows.push_back(row_of(i == 0, 48'h0, 32'h0, 48'h0, 48'h7FFF_7FFF_7FFF,
                            48'h8000_8000_8000, 0, 0, 0, 60'h0, 60'h0, 0));
    foreach (rows[i]) send_vertex(rows[i]);

    set_tolerance(8'd1);
    run_meshes(110);
    set_tolerance(8'd255);
    run_meshes(110);
    set_tolerance(8'd0);
    run_meshes(80);
    set_tolerance(tol_t'($urandom_range(2, 20)));
    run_meshes(140);
    set_tolerance(tol_t'($urandom_range(21, 254)));
    run_meshes(140);
    set_tolerance(8'd1);
    fill_table();
    run_meshes(20);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d vertices: %0d new, %0d merged, %0d dropped on a full table.",
             n_new + n_merged + n_dropped, n_new, n_merged, n_dropped);
    $display("Used %0d tolerance writes; the table peaked at %0d unique entries.",
             n_tols, peak_count);
    if (mismatches == 0) begin
      $display("tolerant_vertex_dedup_indexer test passed");
    end else begin
      $display("tolerant_vertex_dedup_indexer test failed");
    end
    $finish;
  end

endmodule
